### rtl/ry420_pkg.sv
// Shared types and constants for the 2x2 RGB to YCbCr 4:2:0 converter.
// No dependencies; imported by every module of the block.
package ry420_pkg;

	localparam int unsigned PIX_PER_BLK = 4;
	localparam int unsigned CH_W        = 8;
	localparam int unsigned SUM_W       = 10;   // four 8-bit samples
	localparam int unsigned LPROD_W     = 24;   // luma term and accumulator
	localparam int unsigned CPROD_W     = 25;   // chroma product of a channel sum
	localparam int unsigned CACC_W      = 28;   // signed chroma accumulator

	// Luma coefficients, unsigned Q16
	localparam logic [15:0] Y_KB  = 16'd6423;
	localparam logic [15:0] Y_KG  = 16'd33030;
	localparam logic [15:0] Y_KR  = 16'd16843;
	localparam logic [LPROD_W-1:0] Y_OFS = 24'd1081344;  // 16.5 in Q16
	localparam logic [7:0] Y_MIN = 8'd16;
	localparam logic [7:0] Y_MAX = 8'd235;

	// Chroma coefficients, Q16 applied to channel sums (Q18 after the /4)
	localparam logic [14:0] C_HI  = 15'd28770;
	localparam logic [14:0] CB_KG = 15'd19071;
	localparam logic [14:0] CB_KR = 15'd9699;
	localparam logic [14:0] CR_KG = 15'd24117;
	localparam logic [14:0] CR_KB = 15'd4653;
	localparam logic signed [CACC_W-1:0] C_OFS = 28'sd33685504;  // 128.5 in Q18
	localparam logic [9:0] C_MIN = 10'd16;
	localparam logic [9:0] C_MAX = 10'd240;

	// Per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

endpackage

### rtl/ry420_luma_lane.sv
// One luma lane: three Q16 products, then sum, shift and clamp to 16..235.
// Depends on ry420_pkg.
module ry420_luma_lane import ry420_pkg::*; (
	input  logic            clk,
	input  pipe_en_t        en,
	input  logic [CH_W-1:0] blue,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] red,
	output logic [CH_W-1:0] luma_s2
);

	logic [LPROD_W-1:0] pb_s1, pg_s1, pr_s1;
	logic [LPROD_W-1:0] acc;
	logic [CH_W-1:0]    yraw;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			pb_s1 <= {8'd0, Y_KB} * {16'd0, blue};
			pg_s1 <= {8'd0, Y_KG} * {16'd0, green};
			pr_s1 <= {8'd0, Y_KR} * {16'd0, red};
		end
	end

	assign acc  = pb_s1 + pg_s1 + pr_s1 + Y_OFS;
	assign yraw = acc[LPROD_W-1:16];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			if (yraw < Y_MIN)
				luma_s2 <= Y_MIN;
			else if (yraw > Y_MAX)
				luma_s2 <= Y_MAX;
			else
				luma_s2 <= yraw;
		end
	end

endmodule

### rtl/ry420_chroma_merge.sv
// Merge stage: sums the four pixels' channels, forms Cb and Cr in Q18, clamps.
// Depends on ry420_pkg.
module ry420_chroma_merge import ry420_pkg::*; (
	input  logic                              clk,
	input  pipe_en_t                          en,
	input  logic [PIX_PER_BLK-1:0][CH_W-1:0]  blue,
	input  logic [PIX_PER_BLK-1:0][CH_W-1:0]  green,
	input  logic [PIX_PER_BLK-1:0][CH_W-1:0]  red,
	output logic [CH_W-1:0]                   cb_s3,
	output logic [CH_W-1:0]                   cr_s3
);

	logic [SUM_W-1:0]   sb_s1, sg_s1, sr_s1;
	logic [CPROD_W-1:0] ub_s2, ug_s2, ur_s2;
	logic [CPROD_W-1:0] vr_s2, vg_s2, vb_s2;
	logic signed [CACC_W-1:0] u_acc, v_acc;

	function automatic logic [CH_W-1:0] chroma_clamp(input logic signed [CACC_W-1:0] acc);
		logic [9:0] q;
		q = acc[CACC_W-1:18];
		if (acc <= 0 || q < C_MIN)
			return CH_W'(C_MIN);
		else if (q > C_MAX)
			return CH_W'(C_MAX);
		else
			return q[CH_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sb_s1 <= SUM_W'(blue[0])  + SUM_W'(blue[1])  + SUM_W'(blue[2])  + SUM_W'(blue[3]);
			sg_s1 <= SUM_W'(green[0]) + SUM_W'(green[1]) + SUM_W'(green[2]) + SUM_W'(green[3]);
			sr_s1 <= SUM_W'(red[0])   + SUM_W'(red[1])   + SUM_W'(red[2])   + SUM_W'(red[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ub_s2 <= {10'd0, C_HI}  * {15'd0, sb_s1};
			ug_s2 <= {10'd0, CB_KG} * {15'd0, sg_s1};
			ur_s2 <= {10'd0, CB_KR} * {15'd0, sr_s1};
			vr_s2 <= {10'd0, C_HI}  * {15'd0, sr_s1};
			vg_s2 <= {10'd0, CR_KG} * {15'd0, sg_s1};
			vb_s2 <= {10'd0, CR_KB} * {15'd0, sb_s1};
		end
	end

	assign u_acc = $signed({3'd0, ub_s2}) - $signed({3'd0, ug_s2})
	             - $signed({3'd0, ur_s2}) + C_OFS;
	assign v_acc = $signed({3'd0, vr_s2}) - $signed({3'd0, vg_s2})
	             - $signed({3'd0, vb_s2}) + C_OFS;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			cb_s3 <= chroma_clamp(u_acc);
			cr_s3 <= chroma_clamp(v_acc);
		end
	end

endmodule

### rtl/rgb_to_ycbcr420_block_top.sv
// Top level of the 2x2 RGB to YCbCr 4:2:0 (BT.601 studio range) converter.
// Pipeline: three register stages, s1, s2 and s3, between the input transfer and a valid result.
// Throughput: one block per cycle while m_axis_tready keeps the output moving.
// Rate is set by the three-stage product/sum pipeline: four luma lanes and one chroma merge.
// Each stage holds its data and moves on when the next stage is empty or moving (bubbles collapse).
// Reset (arst_n low, asynchronous) clears the stage valid flags only; data registers hold.
// Depends on ry420_pkg, ry420_luma_lane and ry420_chroma_merge.
module rgb_to_ycbcr420_block_top import ry420_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// per pixel (top_left, top_right, bottom_left, bottom_right), from bit 0 up:
	// blue, green, red; 8 bits each, 96 bits in total
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// from bit 0 up: luma_top_left, luma_top_right, luma_bottom_left,
	// luma_bottom_right, chroma_blue_diff, chroma_red_diff; 8 bits each
	output logic [47:0] m_axis_tdata
);

	pipe_en_t en;
	logic v_s1_q, v_s2_q, v_s3_q;

	logic [PIX_PER_BLK-1:0][CH_W-1:0] blue, green, red;
	logic [PIX_PER_BLK-1:0][CH_W-1:0] luma_s2;
	logic [PIX_PER_BLK-1:0][CH_W-1:0] luma_s3;
	logic [CH_W-1:0] cb_s3, cr_s3;

	// A stage loads when it is empty or its contents move on this cycle.
	assign en.s3 = !v_s3_q || m_axis_tready;
	assign en.s2 = !v_s2_q || en.s3;
	assign en.s1 = !v_s1_q || en.s2;

	assign s_axis_tready = en.s1;
	assign m_axis_tvalid = v_s3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			if (en.s1) v_s1_q <= s_axis_tvalid;
			if (en.s2) v_s2_q <= v_s1_q;
			if (en.s3) v_s3_q <= v_s2_q;
		end
	end

	// Unpack the four pixels; each is 24 bits, blue lowest.
	always_comb begin
		for (int p = 0; p < PIX_PER_BLK; p++) begin
			blue[p]  = s_axis_tdata[p*24 +: 8];
			green[p] = s_axis_tdata[p*24 + 8 +: 8];
			red[p]   = s_axis_tdata[p*24 + 16 +: 8];
		end
	end

	// One luma lane per pixel, all running side by side.
	for (genvar p = 0; p < PIX_PER_BLK; p++) begin : g_lane
		ry420_luma_lane u_lane (
			.clk     (clk),
			.en      (en),
			.blue    (blue[p]),
			.green   (green[p]),
			.red     (red[p]),
			.luma_s2 (luma_s2[p])
		);
	end

	// Chroma takes one more stage than luma; hold luma back to line them up.
	always_ff @(posedge clk) begin
		if (en.s3) luma_s3 <= luma_s2;
	end

	ry420_chroma_merge u_merge (
		.clk   (clk),
		.en    (en),
		.blue  (blue),
		.green (green),
		.red   (red),
		.cb_s3 (cb_s3),
		.cr_s3 (cr_s3)
	);

	assign m_axis_tdata = {cr_s3, cb_s3, luma_s3[3], luma_s3[2], luma_s3[1], luma_s3[0]};

endmodule

### tb/ycbcr420_checker.sv
// Scoreboard for the 2x2 RGB to YCbCr 4:2:0 converter: watches both stream channels,
// predicts each block's luma and chroma and compares the results in order.
// Depends on ry420_pkg for the sample width.
module ycbcr420_checker import ry420_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// per pixel (top_left, top_right, bottom_left, bottom_right), from bit 0 up: blue, green, red
	input  logic [95:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// from bit 0 up: luma tl, tr, bl, br, chroma_blue_diff, chroma_red_diff
	input  logic [47:0] m_axis_tdata,
	output int          mismatch_count,
	output int          pending_results
);

	// BT.601 studio range, luma in Q16 and chroma in Q18 over the four-pixel sums
	localparam int unsigned LUMA_KB  = 6423;
	localparam int unsigned LUMA_KG  = 33030;
	localparam int unsigned LUMA_KR  = 16843;
	localparam int unsigned LUMA_OFS = 1081344;
	localparam int unsigned LUMA_LO  = 16;
	localparam int unsigned LUMA_HI  = 235;
	localparam longint      CHR_MAIN = 28770;
	localparam longint      CB_GREEN = 19071;
	localparam longint      CB_RED   = 9699;
	localparam longint      CR_GREEN = 24117;
	localparam longint      CR_BLUE  = 4653;
	localparam longint      CHR_OFS  = 33685504;
	localparam longint      CHR_LO   = 16;
	localparam longint      CHR_HI   = 240;
	localparam int          REPORT_MAX = 10;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_pix_t;

	typedef struct packed {
		rgb_pix_t bottom_right;
		rgb_pix_t bottom_left;
		rgb_pix_t top_right;
		rgb_pix_t top_left;
	} rgb_quad_t;

	typedef struct packed {
		logic [7:0] cr;
		logic [7:0] cb;
		logic [7:0] y_br;
		logic [7:0] y_bl;
		logic [7:0] y_tr;
		logic [7:0] y_tl;
	} ycc_quad_t;

	localparam string FIELD_NAME [6] = '{"luma_top_left", "luma_top_right",
		"luma_bottom_left", "luma_bottom_right", "chroma_blue_diff", "chroma_red_diff"};

	ycc_quad_t expected_ycc_q[$];
	int        errors;

	function automatic logic [7:0] pixel_luma(rgb_pix_t p);
		int unsigned acc;
		int unsigned y;
		acc = LUMA_KB * p.blue + LUMA_KG * p.green + LUMA_KR * p.red + LUMA_OFS;
		y = acc >> 16;
		if (y < LUMA_LO) y = LUMA_LO;
		if (y > LUMA_HI) y = LUMA_HI;
		return y[7:0];
	endfunction

	// truncate toward zero, then clamp
	function automatic logic [7:0] chroma_clamp(longint acc);
		longint c;
		c = (acc <= 0) ? 0 : (acc >> 18);
		if (c < CHR_LO) c = CHR_LO;
		if (c > CHR_HI) c = CHR_HI;
		return c[7:0];
	endfunction

	function automatic ycc_quad_t convert_block(rgb_quad_t q);
		ycc_quad_t r;
		longint    sb;
		longint    sg;
		longint    sr;
		r.y_tl = pixel_luma(q.top_left);
		r.y_tr = pixel_luma(q.top_right);
		r.y_bl = pixel_luma(q.bottom_left);
		r.y_br = pixel_luma(q.bottom_right);
		sb = longint'(q.top_left.blue) + longint'(q.top_right.blue)
			+ longint'(q.bottom_left.blue) + longint'(q.bottom_right.blue);
		sg = longint'(q.top_left.green) + longint'(q.top_right.green)
			+ longint'(q.bottom_left.green) + longint'(q.bottom_right.green);
		sr = longint'(q.top_left.red) + longint'(q.top_right.red)
			+ longint'(q.bottom_left.red) + longint'(q.bottom_right.red);
		r.cb = chroma_clamp(CHR_MAIN * sb - CB_GREEN * sg - CB_RED * sr + CHR_OFS);
		r.cr = chroma_clamp(CHR_MAIN * sr - CR_GREEN * sg - CR_BLUE * sb + CHR_OFS);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ycc_quad_t want;
		logic [47:0] got;
		logic [47:0] want_bits;
		bit          bad;
		if (!arst_n) begin
			expected_ycc_q.delete();
			errors = 0;
			mismatch_count <= 0;
			pending_results <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_ycc_q.push_back(convert_block(rgb_quad_t'(s_axis_tdata)));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_ycc_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("ERROR @%0t: result %h with none pending", $time, got);
				end else begin
					want = expected_ycc_q.pop_front();
					want_bits = want;
					bad = 1'b0;
					for (int i = 0; i < 6; i++) begin
						if (got[8*i +: 8] !== want_bits[8*i +: 8]) begin
							bad = 1'b1;
							if (errors < REPORT_MAX)
								$display("ERROR @%0t: %s expected %0d got %0d", $time,
									FIELD_NAME[i], want_bits[8*i +: 8], got[8*i +: 8]);
						end
					end
					if (bad) errors++;
				end
			end
			mismatch_count <= errors;
			pending_results <= expected_ycc_q.size();
		end
	end

endmodule

### tb/testbench.sv
// Top of the converter testbench: clock, reset, block stimulus, output back-pressure,
// watchdog and verdict. Depends on rgb_to_ycbcr420_block_top and ycbcr420_checker.
module testbench;

	localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either side
	localparam int DRAIN_CYCLES = 8;     // pipeline is three deep; allow a few more
	localparam int RANDOM_ITEMS = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	int          mismatch_count;
	int          pending_results;
	int          idle_cycles = 0;
	int          burst_left = 0;

	always #5 clk = ~clk;

	rgb_to_ycbcr420_block_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ycbcr420_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// One pixel as it sits in tdata: blue in the low byte, red in the high byte.
	function automatic logic [23:0] pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return {r, g, b};
	endfunction

	function automatic logic [7:0] random_sample(int mode);
		case (mode)
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			2: return $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 3))
				: 8'($urandom_range(0, 3));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Random 2x2 block. Mixes fully random samples, saturated corners of the
	// color cube, near-extreme values and gray pixels.
	function automatic logic [95:0] random_block();
		logic [95:0] blk;
		logic [7:0]  gray;
		int          mode;
		mode = $urandom_range(0, 5);
		for (int p = 0; p < 4; p++) begin
			if (mode == 3) begin
				gray = 8'($urandom_range(0, 255));
				blk[24*p +: 24] = pixel(gray, gray, gray);
			end else begin
				for (int c = 0; c < 3; c++)
					blk[24*p + 8*c +: 8] = random_sample(mode > 3 ? 0 : mode);
			end
		end
		return blk;
	endfunction

	// Offer one block and hold it until the transfer. The sender works in bursts: when a
	// burst runs out, it usually drops valid for a random gap before the next one.
	task automatic send_block(logic [95:0] blk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata  <= blk;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stimulus: directed blocks first, then random ones, then drain and verdict.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black and white blocks: luma floor and top end, neutral chroma
		send_block({4{pixel(8'h00, 8'h00, 8'h00)}});
		send_block({4{pixel(8'hFF, 8'hFF, 8'hFF)}});
		// primaries: Cb and Cr at their highest with pure blue and pure red
		send_block({4{pixel(8'hFF, 8'h00, 8'h00)}});
		send_block({4{pixel(8'h00, 8'hFF, 8'h00)}});
		send_block({4{pixel(8'h00, 8'h00, 8'hFF)}});
		// secondaries: yellow drives Cb to its floor, cyan drives Cr to its floor
		send_block({4{pixel(8'hFF, 8'hFF, 8'h00)}});
		send_block({4{pixel(8'h00, 8'hFF, 8'hFF)}});
		send_block({4{pixel(8'hFF, 8'h00, 8'hFF)}});
		// alternating, single-bit-set and single-bit-clear patterns so every sample bit toggles both ways
		send_block({12{8'hAA}});
		send_block({12{8'h55}});
		send_block({12{8'h01}});
		send_block({12{8'h80}});
		send_block({12{8'hFE}});
		send_block({12{8'h7F}});
		// four different pixels, so each luma lane sees its own value
		send_block({pixel(8'h00, 8'h00, 8'hFF), pixel(8'hFF, 8'h00, 8'h00),
			pixel(8'h00, 8'h00, 8'h00), pixel(8'hFF, 8'hFF, 8'hFF)});
		send_block({pixel(8'hFF, 8'hFF, 8'hFF), pixel(8'h00, 8'hFF, 8'h00),
			pixel(8'hFF, 8'hFF, 8'h00), pixel(8'h00, 8'h00, 8'h00)});
		// a single bright pixel in each corner
		for (int p = 0; p < 4; p++) begin
			logic [95:0] blk;
			blk = '0;
			blk[24*p +: 24] = pixel(8'hFF, 8'hFF, 8'hFF);
			send_block(blk);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_block(random_block());
		s_axis_tvalid <= 1'b0;

		// pending_results is registered in the checker, so step past the
		// last transfer before polling it
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Receiver back-pressure: switch among always-ready, random, periodic and
	// mostly-stalled stretches. Once, early on, hold ready low long enough that
	// the pipeline fills and the block stalls its input.
	initial begin
		int unsigned cyc;
		int          mode;
		int          span;
		bit          held;
		cyc = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && cyc >= 300) begin
				held = 1'b1;
				for (int i = 0; i < 120; i++) begin
					@(posedge clk);
					m_axis_tready <= 1'b0;
					cyc++;
				end
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 150);
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (cyc % 4) != 0;
					default: m_axis_tready <= ($urandom_range(0, 7) == 0);
				endcase
				cyc++;
			end
		end
	end

	// Watchdog: end the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule
